@@ sv/circular_lcp_sorted_search_core_assert.svh @@
// Assertion macros for the circular prefix search core.
// Used by the top level only; no other dependencies.
`ifndef CIRCULAR_LCP_SORTED_SEARCH_CORE_ASSERT_SVH
`define CIRCULAR_LCP_SORTED_SEARCH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CLSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define CLSS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define CLSS_ASSERT(lbl, prop)
`define CLSS_ASSERT_RST(lbl, prop)
`endif
`endif

@@ sv/clss_pkg.sv @@
// Shared types, constants and helpers of the circular prefix search core.
// No dependencies; used by the controller, datapath and top level.
package clss_pkg;

  localparam int WordBits = 64;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] CFG_KEY_BITS    = 2'd1;
  localparam logic [1:0] CFG_ROTATION    = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic init;
    logic plan_mid;
    logic plan_left;
    logic clr;
    logic rd;
    logic narrow;
    logic take;
    logic set_next;
    logic id_rd;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic trigger;
    logic left_lt_right;
    logic last_word;
    logic equal;
    logic has_right;
    logic better;
  } status_t;

  // Leading zero count from bit 63 downward
  function automatic logic [5:0] lzc64(input logic [63:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 6'(63 - i);
    end
    return n;
  endfunction

endpackage

@@ sv/clss_ctrl.sv @@
// Search sequencer: accepts requests, steps probes and word reads, emits results.
// Depends on clss_pkg.
module clss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  clss_pkg::status_t st_i,
  output clss_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PLAN = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_LAST = 3'd3;
  localparam logic [2:0] ST_EVAL = 3'd4;
  localparam logic [2:0] ST_ID   = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam logic [1:0] PH_SRCH = 2'd0;
  localparam logic [1:0] PH_FL   = 2'd1;
  localparam logic [1:0] PH_FR   = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && st_i.trigger) begin
          cmd_o.init = 1'b1;
          state_d    = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cmd_o.clr = 1'b1;
        if (st_i.left_lt_right) begin
          cmd_o.plan_mid = 1'b1;
          phase_d        = PH_SRCH;
        end else begin
          cmd_o.plan_left = 1'b1;
          phase_d         = PH_FL;
        end
        state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        if (st_i.last_word) state_d = ST_LAST;
      end
      ST_LAST: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        case (phase_q)
          PH_SRCH: begin
            if (st_i.equal) begin
              cmd_o.take = 1'b1;
              state_d    = ST_ID;
            end else begin
              cmd_o.narrow = 1'b1;
              state_d      = ST_PLAN;
            end
          end
          PH_FL: begin
            cmd_o.take = 1'b1;
            if (st_i.has_right) begin
              cmd_o.set_next = 1'b1;
              cmd_o.clr      = 1'b1;
              phase_d        = PH_FR;
              state_d        = ST_READ;
            end else begin
              state_d = ST_ID;
            end
          end
          default: begin
            cmd_o.take = st_i.better;
            state_d    = ST_ID;
          end
        endcase
      end
      ST_ID: begin
        cmd_o.id_rd = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_SRCH;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ sv/clss_dpath.sv @@
// Datapath: key and id memories, query words, config, search bounds, compare.
// Depends on clss_pkg.
module clss_dpath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WORDS   = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [10:0]       cfg_data_i,
  input  logic              mode_i,
  input  logic [9:0]        entry_index_i,
  input  logic              word_index_i,
  input  logic [63:0]       key_word_i,
  input  logic [9:0]        object_id_i,
  input  clss_pkg::cmd_t    cmd_i,
  output clss_pkg::status_t st_o,
  output logic [9:0]        position_o,
  output logic [9:0]        found_id_o,
  output logic [7:0]        match_bits_o
);

  localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = IW + 1;
  localparam int WW    = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int KA    = $clog2(TABLE_DEPTH * KEY_WORDS);
  localparam int PW    = WW + 6;
  localparam int KbMax = clss_pkg::WordBits * KEY_WORDS;

  logic [63:0] key_mem [TABLE_DEPTH * KEY_WORDS];
  logic [9:0]  id_mem  [TABLE_DEPTH];
  logic [63:0] query_q [KEY_WORDS];

  logic [10:0] cnt_q;
  logic [7:0]  kbits_q;
  logic [6:0]  rot_q;

  logic [7:0]    kb;
  logic [6:0]    rot;
  logic [CW-1:0] cnt;
  logic [WW-1:0] nw_m1;
  logic          widx_ok, eidx_ok;
  logic [KA-1:0] wr_addr, rd_addr;

  logic [IW-1:0] left_q, right_q, pos_q, best_pos_q;
  logic [7:0]    best_m_q;
  logic [WW-1:0] wc_q, rw_q;
  logic          rd_q;
  logic [63:0]   rdata_q;
  logic [9:0]    id_q;
  logic          hi_f_q, lo_f_q, hi_b_q, lo_b_q;
  logic [PW-1:0] hi_p_q, lo_p_q;
  logic [9:0]    pos_out_q, id_out_q;
  logic [7:0]    m_out_q;

  logic [63:0]   diff, hm, lm;
  logic [5:0]    hz, lz;
  logic [15:0]   pj;
  logic [IW:0]   mid_sum;
  logic [15:0]   m_raw;
  logic [7:0]    m;
  logic          found;

  // Effective configuration with saturation
  always_comb begin
    if (kbits_q == 8'd0) kb = 8'd1;
    else if (32'(kbits_q) > KbMax) kb = 8'(KbMax);
    else kb = kbits_q;
    rot = ({1'b0, rot_q} >= kb) ? 7'(kb - 8'd1) : rot_q;
    if (cnt_q == 11'd0) cnt = CW'(1);
    else if (32'(cnt_q) > TABLE_DEPTH) cnt = CW'(TABLE_DEPTH);
    else cnt = CW'(cnt_q);
    nw_m1   = WW'((kb - 8'd1) >> 6);
    widx_ok = 32'(word_index_i) < KEY_WORDS;
    eidx_ok = 32'(entry_index_i) < TABLE_DEPTH;
    wr_addr = KA'(32'(entry_index_i) * KEY_WORDS + 32'(word_index_i));
    rd_addr = KA'(32'(pos_q) * KEY_WORDS + 32'(wc_q));
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 11'd1024;
      kbits_q <= 8'd128;
      rot_q   <= 7'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        clss_pkg::CFG_ENTRY_COUNT: cnt_q   <= cfg_data_i;
        clss_pkg::CFG_KEY_BITS:    kbits_q <= cfg_data_i[7:0];
        clss_pkg::CFG_ROTATION:    rot_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Table memories and query words
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !mode_i && widx_ok && eidx_ok) begin
      key_mem[wr_addr]          <= key_word_i;
      id_mem[IW'(entry_index_i)] <= object_id_i;
    end
    if (cmd_i.accept && mode_i && widx_ok) query_q[WW'(word_index_i)] <= key_word_i;
    if (cmd_i.rd) rdata_q <= key_mem[rd_addr];
    if (cmd_i.id_rd) id_q <= id_mem[best_pos_q];
  end

  // Masked difference of the word just read
  always_comb begin
    diff = rdata_q ^ query_q[rw_q];
    for (int j = 0; j < 64; j++) begin
      pj          = 16'({rw_q, 6'(j)});
      hm[63 - j]  = diff[63 - j] && pj >= 16'(rot) && pj < 16'(kb);
      lm[63 - j]  = diff[63 - j] && pj < 16'(rot);
    end
    hz = clss_pkg::lzc64(hm);
    lz = clss_pkg::lzc64(lm);
  end

  // Probe outcome
  always_comb begin
    found   = hi_f_q | lo_f_q;
    m_raw   = hi_f_q ? 16'(hi_p_q) - 16'(rot) : 16'(lo_p_q) + 16'(kb) - 16'(rot);
    m       = found ? m_raw[7:0] : kb;
    mid_sum = ({1'b0, left_q} + {1'b0, right_q} + 1'b1) >> 1;
    st_o.trigger       = mode_i && widx_ok && (WW'(word_index_i) == nw_m1);
    st_o.left_lt_right = left_q < right_q;
    st_o.last_word     = wc_q == nw_m1;
    st_o.equal         = !found;
    st_o.has_right     = ({1'b0, pos_q} + 1'b1) < cnt;
    st_o.better        = m > best_m_q;
  end

  // Search registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wc_q <= '0;
    end else begin
      rd_q <= cmd_i.rd;
      if (cmd_i.clr) wc_q <= '0;
      else if (cmd_i.rd) wc_q <= wc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rw_q <= wc_q;
    if (cmd_i.init) begin
      left_q  <= '0;
      right_q <= IW'(cnt - 1'b1);
    end
    if (cmd_i.plan_mid) pos_q <= mid_sum[IW-1:0];
    if (cmd_i.plan_left) pos_q <= left_q;
    if (cmd_i.set_next) pos_q <= pos_q + 1'b1;
    if (cmd_i.narrow) begin
      if (hi_f_q ? !hi_b_q : !lo_b_q) left_q <= pos_q;
      else right_q <= pos_q - 1'b1;
    end
    if (cmd_i.take) begin
      best_pos_q <= pos_q;
      best_m_q   <= m;
    end
    // Keep the earliest differing bit of each half of the circle
    if (cmd_i.clr) begin
      hi_f_q <= 1'b0;
      lo_f_q <= 1'b0;
    end else if (rd_q) begin
      if (!hi_f_q && hm != 64'd0) begin
        hi_f_q <= 1'b1;
        hi_p_q <= {rw_q, hz};
        hi_b_q <= rdata_q[6'd63 - hz];
      end
      if (!lo_f_q && lm != 64'd0) begin
        lo_f_q <= 1'b1;
        lo_p_q <= {rw_q, lz};
        lo_b_q <= rdata_q[6'd63 - lz];
      end
    end
    if (cmd_i.emit) begin
      pos_out_q <= 10'(32'(best_pos_q));
      id_out_q  <= id_q;
      m_out_q   <= best_m_q;
    end
  end

  assign position_o   = pos_out_q;
  assign found_id_o   = id_out_q;
  assign match_bits_o = m_out_q;

endmodule

@@ sv/circular_lcp_sorted_search_core.sv @@
// Channel   Handshake              Payload
// in        in_valid_i/in_stall_o  mode, entry_index, word_index, key_word, object_id
// out       out_valid_o/out_stall_i position, found_id, match_bits
// cfg       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Load items and non-final query words are taken without holding the input.
// A completing query holds the input after its accept until its result is emitted;
// each search probe reads the key words through the single key memory read
// port, one 64-bit word a cycle.
// Asynchronous active-low reset clears control; tables are undefined until loaded.
// Input is taken while a result waits in the output register.
// Depends on clss_pkg, clss_ctrl, clss_dpath and the assertion header.
`include "circular_lcp_sorted_search_core_assert.svh"
module circular_lcp_sorted_search_core #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WORDS   = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [9:0]  entry_index_i,
  input  logic        word_index_i,
  input  logic [63:0] key_word_i,
  input  logic [9:0]  object_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  position_o,
  output logic [9:0]  found_id_o,
  output logic [7:0]  match_bits_o
);

  clss_pkg::cmd_t    cmd;
  clss_pkg::status_t st;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  clss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Storage and compare
  clss_dpath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WORDS  (KEY_WORDS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (mode_i),
    .entry_index_i(entry_index_i),
    .word_index_i (word_index_i),
    .key_word_i   (key_word_i),
    .object_id_i  (object_id_i),
    .cmd_i        (cmd),
    .st_o         (st),
    .position_o   (position_o),
    .found_id_o   (found_id_o),
    .match_bits_o (match_bits_o)
  );

  // A new result only follows a busy cycle
  `CLSS_ASSERT(a_rise_busy, $rose(out_valid_o) |-> $past(in_stall_o))
  // A completing query request starts a search
  `CLSS_ASSERT(a_trig_busy, (in_valid_i && !in_stall_o && st.trigger) |=> in_stall_o)
  // No result during reset
  `CLSS_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_o)

endmodule

@@ bench/circular_lcp_sorted_search_core_tb.sv @@
// Self-checking bench for the circular prefix search core: loads sorted key
// tables, sends query keys and checks each result against an in-bench predictor.
// Depends on clss_pkg and the circular_lcp_sorted_search_core top level.
`timescale 1ns / 1ps
module circular_lcp_sorted_search_core_tb;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int   DEPTH      = 1024;
  localparam int   SETTLE     = 200;
  localparam int   CYCLE_CAP  = 3000000;

  typedef struct packed {
    logic        mode;
    logic [9:0]  entry_index;
    logic        word_index;
    logic [63:0] key_word;
    logic [9:0]  object_id;
  } request_t;

  typedef struct packed {
    logic [9:0] position;
    logic [9:0] found_id;
    logic [7:0] match_bits;
  } hit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = clss_pkg::CFG_ENTRY_COUNT;
  logic [10:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = MODE_LOAD;
  logic [9:0]  entry_index_i = '0;
  logic        word_index_i = 1'b0;
  logic [63:0] key_word_i = '0;
  logic [9:0]  object_id_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [9:0]  position_o;
  logic [9:0]  found_id_o;
  logic [7:0]  match_bits_o;

  circular_lcp_sorted_search_core u_top (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: table contents, query words and register copies
  logic [63:0] key_tab [2*DEPTH];
  logic [9:0]  id_tab [DEPTH];
  logic [63:0] qry [2];
  logic [10:0] reg_count = 11'd1024;
  logic [7:0]  reg_kbits = 8'd128;
  logic [6:0]  reg_rot   = 7'd0;

  request_t pending_q [$];
  hit_t     hits_q [$];
  int       errors = 0;
  int       cycles = 0;
  logic     in_fire = 1'b0;

  // Effective settings after the zero and saturation rules
  function automatic int eff_kbits();
    int kb;
    kb = reg_kbits;
    if (kb == 0) kb = 1;
    if (kb > 128) kb = 128;
    return kb;
  endfunction

  function automatic int eff_count();
    int c;
    c = reg_count;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic int eff_rot(int kb);
    return (reg_rot >= kb) ? kb - 1 : reg_rot;
  endfunction

  // Circular bit string as an integer, first compared bit on top
  function automatic logic [127:0] circ_val(logic [63:0] w0, logic [63:0] w1, int kb, int rot);
    logic [127:0] v;
    logic [127:0] k;
    int p;
    v = '0;
    k = {w0, w1};
    for (int i = 0; i < kb; i++) begin
      p = rot + i;
      if (p >= kb) p -= kb;
      v = {v[126:0], k[127-p]};
    end
    return v;
  endfunction

  // Compare entry with the query: -1 smaller, 1 larger, 0 equal; count matching bits
  function automatic int probe(int pos, int kb, int rot, output int matched);
    logic [127:0] e;
    logic [127:0] q;
    int p;
    e = {key_tab[2*pos], key_tab[2*pos+1]};
    q = {qry[0], qry[1]};
    for (int i = 0; i < kb; i++) begin
      p = rot + i;
      if (p >= kb) p -= kb;
      if (e[127-p] != q[127-p]) begin
        matched = i;
        return e[127-p] ? 1 : -1;
      end
    end
    matched = kb;
    return 0;
  endfunction

  // Apply one accepted request to the predictor; queue the search result if any
  task automatic predict_search(request_t r);
    int kb, rot, cnt, lo, hi, mid, m, lm, rm, res;
    bit hit;
    hit_t h;
    if (r.mode == MODE_LOAD) begin
      key_tab[2*r.entry_index + r.word_index] = r.key_word;
      id_tab[r.entry_index] = r.object_id;
    end else begin
      qry[r.word_index] = r.key_word;
      kb = eff_kbits();
      if (r.word_index == ((kb + 63) / 64) - 1) begin
        cnt = eff_count();
        rot = eff_rot(kb);
        lo = 0;
        hi = cnt - 1;
        hit = 1'b0;
        lm = 0;
        while (lo < hi && !hit) begin
          mid = (lo + hi + 1) / 2;
          res = probe(mid, kb, rot, m);
          if (res == 0) begin
            lo = mid;
            lm = m;
            hit = 1'b1;
          end else if (res < 0) lo = mid;
          else hi = mid - 1;
        end
        if (!hit) begin
          void'(probe(lo, kb, rot, lm));
          if (lo + 1 < cnt) begin
            void'(probe(lo + 1, kb, rot, rm));
            if (rm > lm) begin
              lo = lo + 1;
              lm = rm;
            end
          end
        end
        h.position   = lo[9:0];
        h.found_id   = id_tab[lo];
        h.match_bits = (lm > 255) ? 8'd255 : lm[7:0];
        hits_q.push_back(h);
      end
    end
  endtask

  // Accept side: track requests, feed the predictor, check results, guard time
  always @(posedge clk_i) begin
    hit_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t timeout", $time);
      $display("Mismatches found");
      $finish;
    end else begin
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o)
        predict_search('{mode_i, entry_index_i, word_index_i, key_word_i, object_id_i});
      if (out_valid_o && !out_stall_i) begin
        if (hits_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result pos=%0d id=%0d bits=%0d", $time,
                   position_o, found_id_o, match_bits_o);
        end else begin
          want = hits_q.pop_front();
          if (want.position !== position_o) begin
            errors++;
            $display("%0t position exp=%0d act=%0d", $time, want.position, position_o);
          end
          if (want.found_id !== found_id_o) begin
            errors++;
            $display("%0t found_id exp=%0d act=%0d", $time, want.found_id, found_id_o);
          end
          if (want.match_bits !== match_bits_o) begin
            errors++;
            $display("%0t match_bits exp=%0d act=%0d", $time, want.match_bits, match_bits_o);
          end
        end
      end
    end
  end

  // Request driver: bursts of random length separated by random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(negedge clk_i) begin
    request_t r;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left > 0 || pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        r = pending_q.pop_front();
        in_valid_i    <= 1'b1;
        mode_i        <= r.mode;
        entry_index_i <= r.entry_index;
        word_index_i  <= r.word_index;
        key_word_i    <= r.key_word;
        object_id_i   <= r.object_id;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // Result stall pattern: free-flowing, light and heavy stretches
  int stall_kind = 0;
  int stall_span = 50;
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_kind <= $urandom_range(0, 2);
      stall_span <= $urandom_range(20, 300);
    end else stall_span <= stall_span - 1;
    case (stall_kind)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Register write over the configuration channel
  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      clss_pkg::CFG_ENTRY_COUNT: reg_count = val;
      clss_pkg::CFG_KEY_BITS:    reg_kbits = val[7:0];
      default:                   reg_rot   = val[6:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid_i || hits_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  logic [63:0]  gen_w [DEPTH][2];
  logic [127:0] gen_c [DEPTH];

  // Load entries 0..n-1 with random keys sorted along the circular string
  task automatic load_sorted(int n);
    logic [63:0] t0, t1;
    logic [127:0] tc;
    int kb, rot, j;
    kb = eff_kbits();
    rot = eff_rot(kb);
    for (int i = 0; i < n; i++) begin
      t0 = {$urandom, $urandom};
      t1 = {$urandom, $urandom};
      tc = circ_val(t0, t1, kb, rot);
      j = i;
      while (j > 0 && gen_c[j-1] > tc) begin
        gen_w[j] = gen_w[j-1];
        gen_c[j] = gen_c[j-1];
        j--;
      end
      gen_w[j][0] = t0;
      gen_w[j][1] = t1;
      gen_c[j] = tc;
    end
    for (int i = 0; i < n; i++)
      for (int w = 0; w < 2; w++)
        pending_q.push_back('{MODE_LOAD, i[9:0], w[0], gen_w[i][w], 10'($urandom)});
  endtask

  // Queue one query key; final word triggers the search
  task automatic send_query(logic [63:0] w0, logic [63:0] w1);
    if (eff_kbits() > 64) begin
      pending_q.push_back('{MODE_QUERY, 10'($urandom), 1'b0, w0, 10'($urandom)});
      pending_q.push_back('{MODE_QUERY, 10'($urandom), 1'b1, w1, 10'($urandom)});
    end else begin
      // stray upper word is only stored
      if ($urandom_range(0, 9) == 0)
        pending_q.push_back('{MODE_QUERY, 10'($urandom), 1'b1, w1, 10'($urandom)});
      pending_q.push_back('{MODE_QUERY, 10'($urandom), 1'b0, w0, 10'($urandom)});
    end
  endtask

  // Random queries: mostly near table keys, some fully random
  task automatic random_queries(int n, int cnt);
    logic [127:0] k;
    int e;
    for (int i = 0; i < n; i++) begin
      e = $urandom_range(0, cnt - 1);
      k = {gen_w[e][0], gen_w[e][1]};
      case ($urandom_range(0, 3))
        0: ;
        1: k[$urandom_range(0, 127)] ^= 1'b1;
        2: k ^= 128'(1) << $urandom_range(0, 127) | 128'(1) << $urandom_range(0, 127);
        default: k = {$urandom, $urandom, $urandom, $urandom};
      endcase
      send_query(k[127:64], k[63:0]);
    end
  endtask

  int phase_cnt [9] = '{48, 1, 0, 20, 2, 37, 50, 16, 3};
  int phase_kb  [9] = '{128, 1, 0, 255, 64, 65, 100, 128, 8};
  int phase_rot [9] = '{0, 0, 3, 127, 63, 64, 99, 127, 5};

  initial begin
    int c, kb, rot, n;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int ph = 0; ph < 13; ph++) begin
      wait_idle();
      if (ph < 9) begin
        c = phase_cnt[ph];
        kb = phase_kb[ph];
        rot = phase_rot[ph];
      end else begin
        c = $urandom_range(1, 64);
        kb = $urandom_range(1, 128);
        rot = $urandom_range(0, 127);
      end
      write_reg(clss_pkg::CFG_ENTRY_COUNT, c[10:0]);
      write_reg(clss_pkg::CFG_KEY_BITS, kb[10:0]);
      write_reg(clss_pkg::CFG_ROTATION, rot[10:0]);
      n = eff_count();
      load_sorted(n);
      if (ph == 0) begin
        // Directed: exact hits at both ends, extreme keys, single bit off
        send_query(gen_w[0][0], gen_w[0][1]);
        send_query(gen_w[n-1][0], gen_w[n-1][1]);
        send_query('0, '0);
        send_query('1, '1);
        send_query(gen_w[n/2][0], gen_w[n/2][1] ^ 64'h1);
        send_query(gen_w[7][0] ^ 64'h8000_0000_0000_0000, gen_w[7][1]);
        send_query(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        // out-of-order reload of the last entry, then search it
        pending_q.push_back('{MODE_LOAD, 10'(n - 1), 1'b0, '1, 10'h3ff});
        pending_q.push_back('{MODE_LOAD, 10'(n - 1), 1'b1, '1, 10'h3ff});
        gen_w[n-1][0] = '1;
        gen_w[n-1][1] = '1;
        send_query('1, '1);
        random_queries(20, n);
      end else begin
        send_query(gen_w[0][0], gen_w[0][1]);
        random_queries(12, n);
      end
    end
    wait_idle();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
